// ----- hdl/ecpb_pkg.sv -----
// shared constants and types for the exact color palette builder
package ecpb_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
	localparam int CHAN_W = 8;
	localparam int WORD_W = 4 * CHAN_W;
	localparam int SLOT_W = 9;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
	localparam logic [SLOT_W-1:0] NO_SLOT = '1;

	// palette write request
	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ecpb_wr_t;

	// compare result of one palette entry read through the registered port
	typedef struct packed {
		logic vld;
		logic match;
		logic [IDX_W-1:0] idx;
	} ecpb_cmp_t;

endpackage

// ----- hdl/ecpb_store.sv -----
// palette memory with registered read port and entry compare stage
module ecpb_store
	import ecpb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  ecpb_wr_t wr,
	input  logic rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [WORD_W-1:0] key,
	output ecpb_cmp_t cmp
);

	logic [WORD_W-1:0] mem [PALETTE_SIZE];
	logic [WORD_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_idx_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
		end
	end

	always_comb begin
		cmp.vld = rd_vld_q;
		cmp.match = rd_vld_q && (rd_data_q == key);
		cmp.idx = rd_idx_q;
	end

endmodule

// ----- hdl/exact_color_palette_builder.sv -----
// Exact color palette builder: maps RGBA pixels to palette indices, one result per pixel.
// A transparent pixel (alpha zero) or a pixel already answered by the sticky palette-full
// status goes from idle straight to the done state, which loads its result into the
// output register. An opaque pixel scans the palette in ascending order through one read
// port and one 32-bit comparator, one entry per cycle. A match ends the scan at the first
// matching entry; a miss appends a new entry, or sets the full status if none is free.
// in_ready is high only between pixels. A finished result sits in the output register
// while the next pixel is taken. A result that has not been taken holds the block in its
// done state until out_ready frees the output register. After a pixel marked last the
// palette, the transparent slot and the full status are cleared; memory contents are
// not swept.
module exact_color_palette_builder
	import ecpb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] alpha,
	input  logic last_pixel,
	output logic out_valid,
	input  logic out_ready,
	output logic [IDX_W-1:0] color_index,
	output logic status,
	output logic added,
	output logic [CNT_W-1:0] entries_used,
	output logic signed [SLOT_W-1:0] transparent_slot,
	output logic last_out
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	logic [WORD_W-1:0] word_q;
	logic last_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic trans_vld_q;
	logic [IDX_W-1:0] trans_q;
	logic ovf_q;
	logic [IDX_W-1:0] res_idx_q;
	logic res_added_q;

	logic out_valid_q;
	logic [IDX_W-1:0] color_index_q;
	logic status_q;
	logic added_q;
	logic [CNT_W-1:0] entries_used_q;
	logic [SLOT_W-1:0] transparent_slot_q;
	logic last_out_q;

	ecpb_wr_t wr;
	ecpb_cmp_t cmp;
	logic rd_en;
	logic hit;
	logic issue;
	logic is_full;
	logic accept;
	logic miss_done;

	ecpb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd_addr(scan_q[IDX_W-1:0]),
		.key    (word_q),
		.cmp    (cmp)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign is_full = (count_q == CNT_W'(PALETTE_SIZE));
	assign hit = cmp.vld && cmp.match;
	assign issue = (state_q == S_SCAN) && !hit && (scan_q < count_q);
	assign rd_en = issue;
	// scan exhausted with nothing left in the compare stage
	assign miss_done = (state_q == S_SCAN) && !hit && !issue && !cmp.vld;

	always_comb begin
		wr.en = 1'b0;
		wr.addr = count_q[IDX_W-1:0];
		wr.data = word_q;
		if (accept && !ovf_q && (alpha == '0) && !trans_vld_q && !is_full) begin
			wr.en = 1'b1;
			wr.data = '0;
		end else if (miss_done && !is_full) begin
			wr.en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			trans_vld_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						word_q <= {red, green, blue, alpha};
						last_q <= last_pixel;
						scan_q <= '0;
						res_idx_q <= '0;
						res_added_q <= 1'b0;
						if (ovf_q) begin
							state_q <= S_DONE;
						end else if (alpha == '0) begin
							state_q <= S_DONE;
							if (trans_vld_q) begin
								res_idx_q <= trans_q;
							end else if (is_full) begin
								ovf_q <= 1'b1;
							end else begin
								trans_vld_q <= 1'b1;
								trans_q <= count_q[IDX_W-1:0];
								count_q <= count_q + 1'b1;
								res_idx_q <= count_q[IDX_W-1:0];
								res_added_q <= 1'b1;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_idx_q <= cmp.idx;
						state_q <= S_DONE;
					end else if (issue) begin
						scan_q <= scan_q + 1'b1;
					end else if (miss_done) begin
						state_q <= S_DONE;
						if (is_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
							res_idx_q <= count_q[IDX_W-1:0];
							res_added_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						color_index_q <= ovf_q ? '0 : res_idx_q;
						status_q <= ovf_q ? STATUS_FULL : STATUS_OK;
						added_q <= ovf_q ? 1'b0 : res_added_q;
						entries_used_q <= count_q;
						transparent_slot_q <= trans_vld_q ? {{(SLOT_W-IDX_W){1'b0}}, trans_q}
							: NO_SLOT;
						last_out_q <= last_q;
						// end of image clears the table
						if (last_q) begin
							count_q <= '0;
							trans_vld_q <= 1'b0;
							ovf_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign color_index = color_index_q;
	assign status = status_q;
	assign added = added_q;
	assign entries_used = entries_used_q;
	assign transparent_slot = transparent_slot_q;
	assign last_out = last_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PALETTE_SIZE))
		else $error("entry count beyond palette size");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !is_full)
		else $error("palette write while full");

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp.vld |-> (state_q == S_SCAN))
		else $error("compare result outside scan");

	a_added_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(added_q && (status_q == STATUS_FULL)))
		else $error("entry added with palette full status");

	a_trans_held: assert property (@(posedge clk) disable iff (!arst_n)
		trans_vld_q |-> ({1'b0, trans_q} < count_q))
		else $error("transparent slot beyond entry count");

endmodule

// ----- bench/exact_color_palette_builder_tb.sv -----
// testbench for the exact color palette builder: random images checked against a palette predictor
module exact_color_palette_builder_tb;
	import ecpb_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic last;
	} pixel_t;

	typedef struct packed {
		logic [IDX_W-1:0] color_index;
		logic status;
		logic added;
		logic [CNT_W-1:0] entries_used;
		logic signed [SLOT_W-1:0] transparent_slot;
		logic last_out;
	} palette_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CHAN_W-1:0] red = '0;
	logic [CHAN_W-1:0] green = '0;
	logic [CHAN_W-1:0] blue = '0;
	logic [CHAN_W-1:0] alpha = '0;
	logic last_pixel = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] color_index;
	logic status;
	logic added;
	logic [CNT_W-1:0] entries_used;
	logic signed [SLOT_W-1:0] transparent_slot;
	logic last_out;

	pixel_t pending_pixels[$];
	palette_result_t expected_results[$];
	pixel_t drv_pixel;
	int sent_count = 0;
	int total_pixels = 1;
	int mismatch_count = 0;

	// palette predictor state
	logic [WORD_W-1:0] color_table [PALETTE_SIZE];
	int table_count = 0;
	bit has_clear_entry = 1'b0;
	int clear_entry_slot = 0;
	bit table_overflow = 1'b0;

	always #4 clk = ~clk;

	exact_color_palette_builder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.color_index(color_index),
		.status(status),
		.added(added),
		.entries_used(entries_used),
		.transparent_slot(transparent_slot),
		.last_out(last_out)
	);

	function automatic palette_result_t map_pixel(pixel_t px);
		palette_result_t res;
		logic [WORD_W-1:0] word;
		int idx;
		int hit;
		int c;
		bit add;
		idx = 0;
		add = 1'b0;
		if (!table_overflow) begin
			if (px.alpha == '0) begin
				if (!has_clear_entry) begin
					if (table_count < PALETTE_SIZE) begin
						color_table[table_count] = '0;
						clear_entry_slot = table_count;
						has_clear_entry = 1'b1;
						table_count++;
						add = 1'b1;
					end else begin
						table_overflow = 1'b1;
					end
				end
				if (!table_overflow)
					idx = clear_entry_slot;
			end else begin
				word = {px.red, px.green, px.blue, px.alpha};
				hit = -1;
				for (c = 0; c < table_count; c++)
					if (hit < 0 && color_table[c] == word)
						hit = c;
				if (hit >= 0) begin
					idx = hit;
				end else if (table_count < PALETTE_SIZE) begin
					color_table[table_count] = word;
					idx = table_count;
					table_count++;
					add = 1'b1;
				end else begin
					table_overflow = 1'b1;
				end
			end
		end
		res.color_index = table_overflow ? '0 : idx[IDX_W-1:0];
		res.status = table_overflow ? STATUS_FULL : STATUS_OK;
		res.added = table_overflow ? 1'b0 : add;
		res.entries_used = table_count[CNT_W-1:0];
		res.transparent_slot = has_clear_entry ? clear_entry_slot[SLOT_W-1:0] : NO_SLOT;
		res.last_out = px.last;
		// end of image wipes the palette
		if (px.last) begin
			table_count = 0;
			has_clear_entry = 1'b0;
			clear_entry_slot = 0;
			table_overflow = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// 0: sender light idle, receiver heavy; 1: the reverse; 2: no idling
	function automatic int idle_phase();
		return (sent_count * 3) / total_pixels;
	endfunction

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic [7:0] a, input logic last);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.alpha = a;
		px.last = last;
		pending_pixels.push_back(px);
	endtask

	// fills the palette to the brim, then forces the full status and keeps it sticky
	task automatic add_overflow_image(input bit transparent_trigger);
		pixel_t fill[$];
		pixel_t px;
		int trans_at;
		int made;
		int tail_len;
		int k;
		int pick;
		trans_at = transparent_trigger ? -1 : $urandom_range(PALETTE_SIZE - 1);
		made = 0;
		while (made < PALETTE_SIZE) begin
			if (fill.size() > 0 && $urandom_range(7) == 0) begin
				pending_pixels.push_back(fill[$urandom_range(fill.size() - 1)]);
			end else if (made == trans_at) begin
				push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'h00, 1'b0);
				made++;
			end else begin
				// blue carries the entry number and alpha stays below ff, so all are new
				px.red = 8'($urandom_range(255));
				px.green = 8'($urandom_range(255));
				px.blue = made[7:0];
				px.alpha = 8'($urandom_range(1, 254));
				px.last = 1'b0;
				fill.push_back(px);
				pending_pixels.push_back(px);
				made++;
			end
		end
		pending_pixels.push_back(fill[$urandom_range(fill.size() - 1)]);
		if (transparent_trigger)
			push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'h00, 1'b0);
		else
			push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'hff, 1'b0);
		tail_len = $urandom_range(2, 5);
		for (k = 0; k < tail_len; k++) begin
			pick = $urandom_range(2);
			if (pick == 0)
				px = fill[$urandom_range(fill.size() - 1)];
			else if (pick == 1)
				px = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'h00, 1'b0};
			else
				px = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'hff, 1'b0};
			px.last = (k == tail_len - 1);
			pending_pixels.push_back(px);
		end
	endtask

	// driver
	always @(posedge clk) begin : pixel_driver
		logic take;
		logic load;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			take = in_valid && in_ready;
			if (take) begin
				expected_results.push_back(map_pixel(drv_pixel));
				sent_count++;
			end
			if (!in_valid || take) begin
				load = pending_pixels.size() != 0 &&
					$urandom_range(99) >= (idle_phase() == 0 ? 16 : idle_phase() == 1 ? 52 : 0);
				if (load) begin
					drv_pixel = pending_pixels.pop_front();
					red <= drv_pixel.red;
					green <= drv_pixel.green;
					blue <= drv_pixel.blue;
					alpha <= drv_pixel.alpha;
					last_pixel <= drv_pixel.last;
				end
				in_valid <= load;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : result_monitor
		palette_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transaction", color_index, '0);
				end else begin
					want = expected_results.pop_front();
					if (color_index !== want.color_index)
						report_mismatch("color_index", color_index, want.color_index);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (added !== want.added)
						report_mismatch("added", added, want.added);
					if (entries_used !== want.entries_used)
						report_mismatch("entries_used", entries_used, want.entries_used);
					if (transparent_slot !== want.transparent_slot)
						report_mismatch("transparent_slot", transparent_slot, want.transparent_slot);
					if (last_out !== want.last_out)
						report_mismatch("last_out", last_out, want.last_out);
				end
			end
			out_ready <= $urandom_range(99) >= (idle_phase() == 0 ? 52 : idle_phase() == 1 ? 16 : 0);
		end
	end

	initial begin : stimulus
		pixel_t pool[$];
		pixel_t px;
		logic [WORD_W-1:0] word;
		int small_count;
		int len;
		int npool;
		int i;
		int pick;
		bit first_full_done;
		bit second_full_done;

		// directed: extremes, transparent sharing, near matches, image ends
		push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		push_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b0);
		push_pixel(8'hff, 8'hff, 8'hff, 8'hfe, 1'b0);
		push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
		push_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1'b0);
		push_pixel(8'h7f, 8'hbf, 8'hdf, 8'hef, 1'b0);
		push_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1'b1);
		push_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b0);
		push_pixel(8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'haa, 8'h55, 8'haa, 8'h55, 1'b1);
		push_pixel(8'h55, 8'haa, 8'h55, 8'h00, 1'b1);
		push_pixel(8'hff, 8'h00, 8'h00, 8'hff, 1'b0);
		push_pixel(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
		push_pixel(8'h00, 8'h00, 8'hff, 8'hff, 1'b0);
		push_pixel(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
		push_pixel(8'hff, 8'h00, 8'h00, 8'hff, 1'b1);

		// random images, mostly short with a small color pool, two of them overflowing
		small_count = 0;
		first_full_done = 1'b0;
		second_full_done = 1'b0;
		while (small_count < 280) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			npool = $urandom_range(1, 10);
			pool.delete();
			repeat (npool) begin
				px = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(1, 255)), 1'b0};
				pool.push_back(px);
			end
			for (i = 0; i < len; i++) begin
				px = pool[$urandom_range(pool.size() - 1)];
				pick = $urandom_range(9);
				if (pick == 0) begin
					px.alpha = '0;
				end else if (pick == 1) begin
					// near match: one bit off a known color
					word = {px.red, px.green, px.blue, px.alpha} ^ (32'd1 << $urandom_range(31));
					{px.red, px.green, px.blue, px.alpha} = word;
				end else if (pick == 2) begin
					px = {8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0};
				end
				px.last = (i == len - 1);
				pending_pixels.push_back(px);
			end
			small_count += len;
			if (!first_full_done && small_count >= 80) begin
				add_overflow_image(1'b0);
				first_full_done = 1'b1;
			end
			if (!second_full_done && small_count >= 200) begin
				add_overflow_image(1'b1);
				second_full_done = 1'b1;
			end
		end
		total_pixels = pending_pixels.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#25000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ecpb_pkg.sv
hdl/ecpb_store.sv
hdl/exact_color_palette_builder.sv
bench/exact_color_palette_builder_tb.sv
